[rtl/ore_pkg.sv]
package ore_pkg;

	localparam logic [6:0] CH_SPACE = 7'h20;
	localparam logic [6:0] CH_UI    = 7'h49;
	localparam logic [6:0] CH_UV    = 7'h56;
	localparam logic [6:0] CH_UX    = 7'h58;
	localparam logic [6:0] CH_UL    = 7'h4C;
	localparam logic [6:0] CH_UC    = 7'h43;
	localparam logic [6:0] CH_UD    = 7'h44;
	localparam logic [6:0] CH_UM    = 7'h4D;
	localparam logic [6:0] CH_LI    = 7'h69;
	localparam logic [6:0] CH_LV    = 7'h76;
	localparam logic [6:0] CH_LX    = 7'h78;
	localparam logic [6:0] CH_LL    = 7'h6C;
	localparam logic [6:0] CH_LC    = 7'h63;
	localparam logic [6:0] CH_LD    = 7'h64;
	localparam logic [6:0] CH_LM    = 7'h6D;

	// slot 0: repeat letter, 1: unit, 2: five, 3: ten
	typedef struct packed {
		logic [2:0]      cnt;
		logic [3:0][1:0] slots;
	} pat_t;

	typedef struct packed {
		logic [2:0] cnt;
		logic [6:0] ch;
		logic       bar;
	} col_info_t;

	function automatic pat_t digit_pattern(input logic [3:0] d, input logic clock);
		pat_t p;
		p.cnt   = 3'd0;
		p.slots = '0;
		unique case (d)
			4'd1: p.cnt = 3'd1;
			4'd2: p.cnt = 3'd2;
			4'd3: p.cnt = 3'd3;
			4'd4: begin
				if (clock) begin
					p.cnt = 3'd4;
				end else begin
					p.cnt   = 3'd2;
					p.slots = {2'd0, 2'd0, 2'd2, 2'd1};
				end
			end
			4'd5: begin
				p.cnt   = 3'd1;
				p.slots = {2'd0, 2'd0, 2'd0, 2'd2};
			end
			4'd6: begin
				p.cnt   = 3'd2;
				p.slots = {2'd0, 2'd0, 2'd1, 2'd2};
			end
			4'd7: begin
				p.cnt   = 3'd3;
				p.slots = {2'd0, 2'd1, 2'd1, 2'd2};
			end
			4'd8: begin
				p.cnt   = 3'd4;
				p.slots = {2'd1, 2'd1, 2'd1, 2'd2};
			end
			4'd9: begin
				p.cnt   = 3'd2;
				p.slots = {2'd0, 2'd0, 2'd3, 2'd1};
			end
			default: p.cnt = 3'd0;
		endcase
		return p;
	endfunction

	function automatic logic [6:0] place_letter(input logic [3:0] p, input logic [1:0] s);
		logic [3:0][6:0] row;
		unique case (p)
			4'd0: row = {CH_UX, CH_UV, CH_UI, CH_UI};
			4'd1: row = {CH_UC, CH_UL, CH_UX, CH_UX};
			4'd2: row = {CH_UM, CH_UD, CH_UC, CH_UC};
			4'd3: row = {CH_UX, CH_UV, CH_UI, CH_UM};
			4'd4: row = {CH_UC, CH_UL, CH_UX, CH_UX};
			4'd5: row = {CH_UM, CH_UD, CH_UC, CH_UC};
			4'd6: row = {CH_LX, CH_LV, CH_LI, CH_UM};
			4'd7: row = {CH_LC, CH_LL, CH_LX, CH_LX};
			4'd8: row = {CH_LM, CH_LD, CH_LC, CH_LC};
			4'd9: row = {CH_LX, CH_LV, CH_LI, CH_LM};
			default: row = '0;
		endcase
		return row[s];
	endfunction

	function automatic logic place_bar(input logic [3:0] p, input logic [1:0] s);
		logic [3:0] row;
		unique case (p)
			4'd3, 4'd9: row = 4'b1110;
			4'd4, 4'd5: row = 4'b1111;
			4'd6:       row = 4'b0001;
			default:    row = 4'b0000;
		endcase
		return row[s];
	endfunction

endpackage

[rtl/ore_div10.sv]
module ore_div10 (
	input  logic [31:0] dividend,
	output logic [31:0] quotient,
	output logic [3:0]  remainder
);
	localparam logic [31:0] RECIP = 32'hCCCC_CCCD;

	logic [63:0] prod;
	logic [31:0] q10;
	logic [31:0] diff;

	// floor(v / 10) = (v * ceil(2^35 / 10)) >> 35, exact for all 32-bit v
	assign prod      = {32'd0, dividend} * {32'd0, RECIP};
	assign quotient  = {3'd0, prod[63:35]};
	assign q10       = (quotient << 3) + (quotient << 1);
	assign diff      = dividend - q10;
	assign remainder = diff[3:0];

endmodule

[rtl/ore_col_lut.sv]
module ore_col_lut (
	input  logic                  clock,
	input  logic [3:0]            digit,
	input  logic [3:0]            place,
	input  logic [1:0]            col,
	output ore_pkg::col_info_t    info
);
	import ore_pkg::*;

	pat_t       pat;
	logic [1:0] slot;

	always_comb begin
		pat      = digit_pattern(digit, clock);
		slot     = pat.slots[col];
		info.cnt = pat.cnt;
		info.ch  = place_letter(place, slot);
		info.bar = place_bar(place, slot);
	end

endmodule

[rtl/overbar_roman_numeral_encoder.sv]
// Extended Roman numeral encoder. Pulse start while busy is low to load value;
// the columns then come out most significant place first, one per strobe, each
// held for exactly one cycle with no way for the receiver to stall them, so it
// must take every strobe. One shared divide-by-ten unit peels off a digit per
// cycle until the remaining value is zero or DECIMAL_DIGITS digits are taken;
// then the emitter walks down the places, sending each column and stepping
// over each zero digit above the lowest nonzero digit, where it stops. The
// final strobe comes in the first cycle that busy reads low, and a new start
// is taken in that same cycle. Zero yields a single blank barred column.
module overbar_roman_numeral_encoder #(
	parameter int DECIMAL_DIGITS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] value,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	output logic        strobe,
	output logic [6:0]  numeral_char,
	output logic        overbar,
	output logic        last
);
	import ore_pkg::*;

	localparam int PW = $clog2(DECIMAL_DIGITS + 1);
	localparam int IW = (DECIMAL_DIGITS > 1) ? $clog2(DECIMAL_DIGITS) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;
	localparam logic [1:0] ST_ZERO = 2'd3;

	logic [1:0]    state_q;
	logic          clockface_q;
	logic [31:0]   v_q;
	logic [PW-1:0] place_q;
	logic [PW-1:0] low_q;
	logic          nz_q;
	logic [1:0]    col_q;
	logic [3:0]    digit_q [DECIMAL_DIGITS];

	logic          strobe_q;
	logic [6:0]    char_q;
	logic          bar_q;
	logic          last_q;

	logic [31:0]   quot;
	logic [3:0]    rem;
	col_info_t     info;
	logic [3:0]    cur_digit;
	logic          col_end;
	logic          is_last;
	logic          div_done;

	ore_div10 u_div10 (
		.dividend  (v_q),
		.quotient  (quot),
		.remainder (rem)
	);

	assign cur_digit = digit_q[place_q[IW-1:0]];

	ore_col_lut u_col_lut (
		.clock (clockface_q),
		.digit (cur_digit),
		.place (4'(place_q)),
		.col   (col_q),
		.info  (info)
	);

	assign col_end  = (({1'b0, col_q} + 3'd1) == info.cnt);
	assign is_last  = col_end && (place_q == low_q);
	assign div_done = (place_q == PW'(DECIMAL_DIGITS)) || (v_q == 32'd0);
	assign busy     = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clockface_q <= 1'b0;
		end else if (cfg_we) begin
			clockface_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= nz_q ? ST_EMIT : ST_ZERO;
					end
				end
				ST_EMIT: begin
					if (info.cnt != 3'd0) begin
						strobe_q <= 1'b1;
						if (is_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_ZERO: begin
					strobe_q <= 1'b1;
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					v_q     <= value;
					place_q <= '0;
					nz_q    <= 1'b0;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					place_q <= place_q - PW'(1);
					col_q   <= 2'd0;
				end else begin
					digit_q[place_q[IW-1:0]] <= rem;
					v_q                      <= quot;
					place_q                  <= place_q + PW'(1);
					// first nonzero digit seen is the lowest one
					if ((rem != 4'd0) && !nz_q) begin
						low_q <= place_q;
						nz_q  <= 1'b1;
					end
				end
			end
			ST_EMIT: begin
				if (info.cnt == 3'd0) begin
					place_q <= place_q - PW'(1);
				end else begin
					char_q <= info.ch;
					bar_q  <= info.bar;
					last_q <= is_last;
					if (col_end) begin
						col_q   <= 2'd0;
						place_q <= place_q - PW'(1);
					end else begin
						col_q <= col_q + 2'd1;
					end
				end
			end
			ST_ZERO: begin
				char_q <= CH_SPACE;
				bar_q  <= 1'b1;
				last_q <= 1'b1;
			end
			default: ;
		endcase
	end

	assign strobe       = strobe_q;
	assign numeral_char = char_q;
	assign overbar      = bar_q;
	assign last         = last_q;

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> !busy)
		else $error("final column shown while still busy");

	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("non-final column shown after sequencer went idle");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	a_blank_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (numeral_char == CH_SPACE) |-> last && overbar)
		else $error("blank column must be the barred final column");

endmodule

[tb/overbar_roman_numeral_encoder_tb.sv]
`timescale 1ns / 100ps

module overbar_roman_numeral_encoder_tb;
	import ore_pkg::*;

	localparam int DEC_DIGITS  = 10;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 64;

	typedef struct packed {
		logic [6:0] ch;
		logic       bar;
		logic       last;
	} column_t;

	// letters per decimal place, indexed by slot: repeat, unit, five, ten
	localparam logic [6:0] PLACE_LETTER [10][4] = '{
		'{CH_UI, CH_UI, CH_UV, CH_UX}, '{CH_UX, CH_UX, CH_UL, CH_UC},
		'{CH_UC, CH_UC, CH_UD, CH_UM}, '{CH_UM, CH_UI, CH_UV, CH_UX},
		'{CH_UX, CH_UX, CH_UL, CH_UC}, '{CH_UC, CH_UC, CH_UD, CH_UM},
		'{CH_UM, CH_LI, CH_LV, CH_LX}, '{CH_LX, CH_LX, CH_LL, CH_LC},
		'{CH_LC, CH_LC, CH_LD, CH_LM}, '{CH_LM, CH_LI, CH_LV, CH_LX}
	};
	// overbar per place, bit n is slot n
	localparam logic [3:0] PLACE_BAR [10] = '{
		4'b0000, 4'b0000, 4'b0000, 4'b1110, 4'b1111,
		4'b1111, 4'b0001, 4'b0000, 4'b0000, 4'b1110
	};
	localparam int DIGIT_LEN [10] = '{0, 1, 2, 3, 2, 1, 2, 3, 4, 2};
	localparam logic [1:0] DIGIT_SLOT [10][4] = '{
		'{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0},
		'{1, 2, 0, 0}, '{2, 0, 0, 0}, '{2, 1, 0, 0}, '{2, 1, 1, 0},
		'{2, 1, 1, 1}, '{1, 3, 0, 0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [31:0] value = '0;
	logic        cfg_we = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        strobe;
	logic [6:0]  numeral_char;
	logic        overbar;
	logic        last;

	logic [31:0] pending_values [$];
	column_t     exp_columns [$];
	logic        clockface = 1'b0;
	int          sender_idle_pct = 0;
	int          stall_cycles = 0;
	int          mismatches = 0;
	int          values_done = 0;
	int          columns_done = 0;
	int          fours_clock = 0;

	overbar_roman_numeral_encoder #(
		.DECIMAL_DIGITS(DEC_DIGITS)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.value       (value),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.strobe      (strobe),
		.numeral_char(numeral_char),
		.overbar     (overbar),
		.last        (last)
	);

	always #1 clk = ~clk;

	function automatic void encode_roman(input logic [31:0] v, input logic four_as_iiii);
		int          digit [DEC_DIGITS];
		int          places;
		int          d;
		int          len;
		logic [1:0]  slot;
		logic [31:0] rem;
		column_t     cols [$];
		column_t     c;
		places = 0;
		rem = v;
		while (places < DEC_DIGITS && rem != 0) begin
			digit[places] = rem % 10;
			rem = rem / 10;
			places++;
		end
		for (int p = places - 1; p >= 0; p--) begin
			d = digit[p];
			len = (d == 4 && four_as_iiii) ? 4 : DIGIT_LEN[d];
			for (int j = 0; j < len; j++) begin
				slot = (d == 4 && four_as_iiii) ? 2'd0 : DIGIT_SLOT[d][j];
				c.ch = PLACE_LETTER[p][slot];
				c.bar = PLACE_BAR[p][slot];
				c.last = 1'b0;
				cols.push_back(c);
			end
		end
		if (cols.size() == 0) begin
			c.ch = CH_SPACE;
			c.bar = 1'b1;
			c.last = 1'b1;
			cols.push_back(c);
		end else begin
			cols[cols.size() - 1].last = 1'b1;
		end
		foreach (cols[i]) exp_columns.push_back(cols[i]);
	endfunction

	function automatic int count_fours(input logic [31:0] v);
		int          n;
		logic [31:0] r;
		n = 0;
		r = v;
		for (int k = 0; k < DEC_DIGITS; k++) begin
			if (r % 10 == 4) n++;
			r = r / 10;
		end
		return n;
	endfunction

	function automatic logic [31:0] random_value();
		longint unsigned acc;
		int              n;
		acc = 0;
		case ($urandom_range(3))
			0: acc = $urandom;
			1: acc = $urandom_range(3999);
			2: begin
				n = $urandom_range(1, 10);
				for (int i = 0; i < n; i++) acc = acc * 10 + $urandom_range(9);
			end
			default: begin
				// heavy on the subtractive and long digits
				n = $urandom_range(1, 10);
				for (int i = 0; i < n; i++) begin
					case ($urandom_range(3))
						0: acc = acc * 10 + 4;
						1: acc = acc * 10 + 8;
						2: acc = acc * 10 + 9;
						default: acc = acc * 10;
					endcase
				end
			end
		endcase
		return acc[31:0];
	endfunction

	// driver: present queued values, predict on each accepted transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			value <= '0;
		end else begin
			if (start && !busy) begin
				encode_roman(value, clockface);
				values_done++;
				if (clockface) fours_clock += count_fours(value);
			end
			if (!start || !busy) begin
				if (pending_values.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
					start <= 1'b1;
					value <= pending_values.pop_front();
				end else begin
					start <= 1'b0;
					value <= $urandom;
				end
			end
		end
	end

	// monitor: every strobe is a transaction, check against the oldest expectation
	always @(posedge clk) begin
		column_t e;
		if (arst_n) begin
			if ((start && !busy) || strobe)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (strobe) begin
				columns_done++;
				if (exp_columns.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected column char=%h bar=%b last=%b", $realtime,
							numeral_char, overbar, last);
				end else begin
					e = exp_columns.pop_front();
					if (numeral_char !== e.ch || overbar !== e.bar || last !== e.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: exp char=%h bar=%b last=%b, got %h %b %b",
								$realtime, e.ch, e.bar, e.last, numeral_char, overbar, last);
					end
				end
			end
		end
	end

	initial begin
		while (stall_cycles < STALL_LIMIT) @(posedge clk);
		$display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	task automatic wait_quiet();
		while (pending_values.size() != 0 || start || busy || exp_columns.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_clockface(input logic mode);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_wdata <= 1'b0;
		clockface = mode;
	endtask

	task automatic run_random(input logic mode, input int idle_pct, input int count);
		write_clockface(mode);
		sender_idle_pct = idle_pct;
		@(negedge clk);
		repeat (count) pending_values.push_back(random_value());
		wait_quiet();
	endtask

	initial begin
		#6 arst_n = 1'b1;

		// register left at its reset value: subtractive fours
		sender_idle_pct = 28;
		@(negedge clk);
		pending_values = '{32'd0, 32'd1, 32'd4, 32'd9, 32'd14, 32'd49, 32'd99, 32'd1994,
			32'd3888, 32'd1000, 32'd1000000, 32'd1000000000, 32'd2147483648,
			32'd3444444444, 32'd3888888888, 32'd4294967295};
		wait_quiet();

		write_clockface(1'b1);
		@(negedge clk);
		pending_values = '{32'd4, 32'd44, 32'd4444, 32'd40000, 32'd1444444444,
			32'd3444444444};
		wait_quiet();

		run_random(1'b1, 28, 50);
		run_random(1'b0, 73, 50);
		run_random(1'b1, 0, 50);

		repeat (DRAIN_WAIT) @(posedge clk);
		mismatches += exp_columns.size();
		$display("Encoded %0d values into %0d checked columns, %0d fours in clockface form,",
			values_done, columns_done, fours_clock);
		$display("with clockface off and on and sender pacing of 28%%, 73%% and 0%% idle.");
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches, %0d columns never arrived", mismatches,
				exp_columns.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/ore_pkg.sv
rtl/ore_div10.sv
rtl/ore_col_lut.sv
rtl/overbar_roman_numeral_encoder.sv
tb/overbar_roman_numeral_encoder_tb.sv
